FILE: sv/stkmax_pkg.sv
// Shared types and codes for the max-tracking stack.
// Used by stkmax_ctrl, stkmax_dp and stack_with_max; depends on nothing.
package stkmax_pkg;

    localparam int WORD_W  = 32;
    localparam int KIND_W  = 2;
    localparam int FAULT_W = 2;
    localparam int FILL_W  = 5;

    // Operation codes carried in the kind field; the unused code acts as no operation.
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOP  = 2'd2;

    localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_PUSH_FULL = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_POP_EMPTY = 2'd2;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // take the input beat this cycle
        logic finish;   // complete a pop whose new top comes from memory
    } t_ctl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;    // output register empty or being drained
        logic need_fetch;  // pending input is a pop that exposes a stored word
    } t_dp_status;

endpackage

FILE: sv/stack_with_max.sv
// Bounded LIFO stack of signed 32-bit words that reports its running maximum.
//
// Input channel: i_in_valid / o_in_stall carry one beat of i_kind and
// i_push_value. Kind push stores a word, pop removes the top word, and the
// other codes only report status. Output channel: o_out_valid / i_out_stall
// carry one result beat per input beat: popped word, new top, maximum, fill
// count, empty and full flags and a fault code (push while full, pop while
// empty; both leave the stack unchanged).
// Results are registered. A pop that leaves at least one word behind first
// reads the new top from the level memory into a read register, then loads
// its result in the fetch state. Throughput: one beat per cycle while the
// receiver does not stall; such a pop holds off the next beat because the new
// top comes through the single registered read port of the level memory. The
// top word and its maximum sit in registers, so a push never waits on memory.
// Reset (synchronous, active low) empties the stack and drops any pending
// result; the level memory is not cleared since only written levels are read.
// When the receiver stalls, the result register holds its beat and the input
// stalls once a new result would need that register.
// Depends on stkmax_pkg, stkmax_ctrl and stkmax_dp.
module stack_with_max #(
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [stkmax_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [stkmax_pkg::WORD_W-1:0] i_push_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [stkmax_pkg::WORD_W-1:0] o_popped_value,
    output logic signed [stkmax_pkg::WORD_W-1:0] o_top_value,
    output logic signed [stkmax_pkg::WORD_W-1:0] o_max_value,
    output logic [stkmax_pkg::FILL_W-1:0]        o_fill_count,
    output logic                                 o_is_empty_flag,
    output logic                                 o_is_full_flag,
    output logic [stkmax_pkg::FAULT_W-1:0]       o_fault
);

    // Commands from the sequencer and status back from the datapath.
    stkmax_pkg::t_ctl_cmd   ctl_cmd;
    stkmax_pkg::t_dp_status dp_status;

    // Sequencer: decides when an input beat is taken and when a deep pop completes.
    stkmax_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (ctl_cmd)
    );

    // Datapath: top registers, level memory with per-level maximum, result register.
    stkmax_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_status        (dp_status),
        .i_kind          (i_kind),
        .i_push_value    (i_push_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_popped_value  (o_popped_value),
        .o_top_value     (o_top_value),
        .o_max_value     (o_max_value),
        .o_fill_count    (o_fill_count),
        .o_is_empty_flag (o_is_empty_flag),
        .o_is_full_flag  (o_is_full_flag),
        .o_fault         (o_fault)
    );

endmodule

FILE: sv/stkmax_ctrl.sv
// Sequencing controller for the max-tracking stack.
// Depends on stkmax_pkg; drives commands into stkmax_dp.
module stkmax_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  stkmax_pkg::t_dp_status  i_status,
    output stkmax_pkg::t_ctl_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FETCH = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd.accept = 1'b0;
        o_cmd.finish = 1'b0;
        o_in_stall   = 1'b1;
        n_state      = r_state;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = !i_status.out_free;
                o_cmd.accept = i_in_valid && i_status.out_free;
                if (o_cmd.accept && i_status.need_fetch) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.finish = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold off input while a fetch is outstanding.
    a_fetch_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> !o_cmd.accept)
        else $error("input accepted during fetch");

    // Enter fetch only after accepting a deep pop.
    a_fetch_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_FETCH) |-> $past(o_cmd.accept && i_status.need_fetch))
        else $error("fetch entered without a deep pop");

    // Never accept and finish in the same cycle.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.accept && o_cmd.finish))
        else $error("accept and finish overlap");

endmodule

FILE: sv/stkmax_dp.sv
// Datapath for the max-tracking stack: top registers, level memory, result register.
// Depends on stkmax_pkg; steered by stkmax_ctrl.
module stkmax_dp #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  stkmax_pkg::t_ctl_cmd                i_cmd,
    output stkmax_pkg::t_dp_status              o_status,
    input  logic [stkmax_pkg::KIND_W-1:0]       i_kind,
    input  logic signed [stkmax_pkg::WORD_W-1:0] i_push_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [stkmax_pkg::WORD_W-1:0] o_popped_value,
    output logic signed [stkmax_pkg::WORD_W-1:0] o_top_value,
    output logic signed [stkmax_pkg::WORD_W-1:0] o_max_value,
    output logic [stkmax_pkg::FILL_W-1:0]       o_fill_count,
    output logic                                o_is_empty_flag,
    output logic                                o_is_full_flag,
    output logic [stkmax_pkg::FAULT_W-1:0]      o_fault
);

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW   = stkmax_pkg::WORD_W;
    localparam int FW   = stkmax_pkg::FILL_W;
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

    // Words below the top level; the top level lives in r_top / r_max.
    logic signed [WW-1:0] mem_word [DEPTH];
    logic signed [WW-1:0] mem_max  [DEPTH];
    logic signed [WW-1:0] r_rd_word;
    logic signed [WW-1:0] r_rd_max;

    logic [CNTW-1:0]      r_count;
    logic [CNTW-1:0]      n_count;
    logic signed [WW-1:0] r_top;
    logic signed [WW-1:0] n_top;
    logic signed [WW-1:0] r_max;
    logic signed [WW-1:0] n_max;
    logic signed [WW-1:0] r_popped;

    logic                 r_out_valid;
    logic signed [WW-1:0] r_out_popped;
    logic signed [WW-1:0] r_out_top;
    logic signed [WW-1:0] r_out_max;
    logic [CNTW-1:0]      r_out_count;
    logic [stkmax_pkg::FAULT_W-1:0] r_out_fault;

    logic                 is_push;
    logic                 is_pop;
    logic                 empty;
    logic                 full;
    logic                 push_ok;
    logic                 pop_ok;
    logic                 need_fetch;
    logic                 load_out;
    logic signed [WW-1:0] push_max;
    logic signed [WW-1:0] out_popped;
    logic [stkmax_pkg::FAULT_W-1:0] out_fault;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [CNTW+FW-1:0]   fill_ext;

    assign is_push    = (i_kind == stkmax_pkg::KIND_PUSH);
    assign is_pop     = (i_kind == stkmax_pkg::KIND_POP);
    assign empty      = (r_count == '0);
    assign full       = (r_count == FULL_CNT);
    assign push_ok    = is_push && !full;
    assign pop_ok     = is_pop && !empty;
    assign need_fetch = pop_ok && (r_count > CNTW'(1));
    assign push_max   = (!empty && (r_max > i_push_value)) ? r_max : i_push_value;
    assign wr_addr    = AW'(r_count - CNTW'(1));
    assign rd_addr    = AW'(r_count - CNTW'(2));

    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.need_fetch = need_fetch;

    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        n_max   = r_max;
        if (i_cmd.accept && push_ok) begin
            n_count = r_count + CNTW'(1);
            n_top   = i_push_value;
            n_max   = push_max;
        end else if (i_cmd.accept && pop_ok) begin
            n_count = r_count - CNTW'(1);
        end
        if (i_cmd.finish) begin
            n_top = r_rd_word;
            n_max = r_rd_max;
        end
    end

    always_comb begin
        out_popped = '0;
        out_fault  = stkmax_pkg::FAULT_NONE;
        if (i_cmd.finish) begin
            out_popped = r_popped;
        end else begin
            if (pop_ok) begin
                out_popped = r_top;
            end
            if (is_push && full) begin
                out_fault = stkmax_pkg::FAULT_PUSH_FULL;
            end else if (is_pop && empty) begin
                out_fault = stkmax_pkg::FAULT_POP_EMPTY;
            end
        end
    end

    assign load_out = (i_cmd.accept && !need_fetch) || i_cmd.finish;

    // Spill the old top below on push; fetch the next top on a deep pop.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && push_ok && !empty) begin
            mem_word[wr_addr] <= r_top;
            mem_max[wr_addr]  <= r_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && need_fetch) begin
            r_rd_word <= mem_word[rd_addr];
            r_rd_max  <= mem_max[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_max <= n_max;
        if (i_cmd.accept && pop_ok) begin
            r_popped <= r_top;
        end
        if (load_out) begin
            r_out_popped <= out_popped;
            r_out_top    <= (n_count == '0) ? '0 : n_top;
            r_out_max    <= (n_count == '0) ? '0 : n_max;
            r_out_count  <= n_count;
            r_out_fault  <= out_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= load_out || (r_out_valid && i_out_stall);
        end
    end

    assign fill_ext        = {{FW{1'b0}}, r_out_count};
    assign o_out_valid     = r_out_valid;
    assign o_popped_value  = r_out_popped;
    assign o_top_value     = r_out_top;
    assign o_max_value     = r_out_max;
    assign o_fill_count    = fill_ext[FW-1:0];
    assign o_is_empty_flag = (r_out_count == '0);
    assign o_is_full_flag  = (r_out_count == FULL_CNT);
    assign o_fault         = r_out_fault;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("stack count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && push_ok) |=> (r_count == $past(r_count) + CNTW'(1)))
        else $error("push did not advance count");

    a_finish_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (r_count != '0))
        else $error("fetch completed on an empty stack");

    a_max_covers_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_is_empty_flag) |-> (r_out_max >= r_out_top))
        else $error("reported maximum below top word");

endmodule
